// File: rtl/assert_macros.svh
// Assertion macros used by the RTL of the sorter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The expression must never be true.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: rtl/mss_pkg.sv
`default_nettype none
package mss_pkg;

	localparam int MAX_ELEMS_DEF = 32;
	localparam int KEY_BITS_DEF  = 32;
	localparam int TAG_BITS      = 16;

	localparam logic REG_SORT_MODE      = 1'b0;
	localparam logic REG_COMPARE_SIGNED = 1'b1;

	typedef enum logic [1:0] {
		MODE_KEEP   = 2'd0,
		MODE_SELECT = 2'd1,
		MODE_BUBBLE = 2'd2,
		MODE_INSERT = 2'd3
	} sort_mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEL_RDI,
		ST_SEL_LDI,
		ST_SEL_SCAN,
		ST_SEL_WR_I,
		ST_SEL_WR_M,
		ST_INS_RD,
		ST_INS_LD,
		ST_INS_CMP,
		ST_INS_WR,
		ST_EMIT_RD,
		ST_EMIT_WAIT
	} back_state_t;

	typedef struct packed {
		logic signed [31:0] key;
		logic [15:0]        tag;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] key_out;
		logic [15:0]        tag_out;
		logic               last_out;
		logic               overflow;
	} out_item_t;

endpackage
`default_nettype wire

// File: rtl/mss_ram.sv
`default_nettype none
module mss_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/mss_front.sv
`default_nettype none
module mss_front import mss_pkg::*; #(
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire in_item_t                     in_data,
	output logic                              q_valid,
	input  wire logic                         q_pop,
	output logic [KEY_BITS+TAG_BITS:0]        q_data
);

	localparam int QW = KEY_BITS + TAG_BITS + 1;

	logic [QW-1:0] slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    fill_q;
	logic [63:0]   key_ext;
	logic [QW-1:0] entry;
	logic          push;

	// The key is sign-extended from 32 bits and kept in KEY_BITS bits.
	assign key_ext  = {{32{in_data.key[31]}}, in_data.key};
	assign entry    = {key_ext[KEY_BITS-1:0], in_data.tag, in_data.last};
	assign in_ready = (fill_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (fill_q != 2'd0);
	assign q_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule
`default_nettype wire

// File: rtl/mss_back.sv
`default_nettype none
module mss_back import mss_pkg::*; #(
	parameter int MAX_ELEMS = MAX_ELEMS_DEF,
	parameter int KEY_BITS  = KEY_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire sort_mode_t                sort_mode,
	input  wire logic                      compare_signed,
	input  wire logic                      q_valid,
	output logic                           q_pop,
	input  wire logic [KEY_BITS+TAG_BITS:0] q_data,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output out_item_t                      out_data
);
	`include "assert_macros.svh"

	localparam int EW = KEY_BITS + TAG_BITS;
	localparam int CW = $clog2(MAX_ELEMS + 1);
	localparam int AW = $clog2(MAX_ELEMS);

	back_state_t   state_q, state_d;
	logic [CW-1:0] cnt_q, n_q, i_q, j_q, m_q;
	logic          drop_q;
	logic [EW-1:0] hold_q, min_q;
	logic          out_valid_q;
	out_item_t     out_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;
	logic [CW-1:0] cnt_new;
	logic          store_ok, is_last, out_free, scan_gt, ins_gt;
	logic [63:0]   key_wide;

	function automatic logic key_gt(input logic [KEY_BITS-1:0] a,
		input logic [KEY_BITS-1:0] b, input logic sgn);
		logic [KEY_BITS-1:0] aa;
		logic [KEY_BITS-1:0] bb;
		aa = a;
		bb = b;
		aa[KEY_BITS-1] = a[KEY_BITS-1] ^ sgn;
		bb[KEY_BITS-1] = b[KEY_BITS-1] ^ sgn;
		return aa > bb;
	endfunction

	mss_ram #(.WIDTH(EW), .DEPTH(MAX_ELEMS)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign store_ok = (cnt_q < CW'(MAX_ELEMS));
	assign cnt_new  = store_ok ? cnt_q + CW'(1) : cnt_q;
	assign is_last  = q_data[0];
	assign out_free = !out_valid_q || out_ready;
	assign scan_gt  = key_gt(min_q[EW-1:TAG_BITS], rdata[EW-1:TAG_BITS], compare_signed);
	assign ins_gt   = key_gt(rdata[EW-1:TAG_BITS], hold_q[EW-1:TAG_BITS], compare_signed);
	assign key_wide = 64'(rdata[EW-1:TAG_BITS]);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid && is_last) begin
					if (cnt_new < CW'(2) || sort_mode == MODE_KEEP) begin
						state_d = ST_EMIT_RD;
					end else if (sort_mode == MODE_SELECT) begin
						state_d = ST_SEL_RDI;
					end else begin
						state_d = ST_INS_RD;
					end
				end
			end
			ST_SEL_RDI:  state_d = ST_SEL_LDI;
			ST_SEL_LDI:  state_d = ST_SEL_SCAN;
			ST_SEL_SCAN: begin
				if (j_q + CW'(1) >= n_q) begin
					state_d = ST_SEL_WR_I;
				end
			end
			ST_SEL_WR_I: state_d = ST_SEL_WR_M;
			ST_SEL_WR_M: begin
				state_d = (i_q + CW'(2) < n_q) ? ST_SEL_RDI : ST_EMIT_RD;
			end
			ST_INS_RD:   state_d = ST_INS_LD;
			ST_INS_LD:   state_d = ST_INS_CMP;
			ST_INS_CMP: begin
				if (!ins_gt || j_q == CW'(1)) begin
					state_d = ST_INS_WR;
				end
			end
			ST_INS_WR: begin
				state_d = (i_q + CW'(1) < n_q) ? ST_INS_RD : ST_EMIT_RD;
			end
			ST_EMIT_RD:  state_d = ST_EMIT_WAIT;
			ST_EMIT_WAIT: begin
				if (out_free) begin
					state_d = (i_q + CW'(1) == n_q) ? ST_IDLE : ST_EMIT_RD;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		we    = 1'b0;
		waddr = cnt_q[AW-1:0];
		wdata = q_data[EW:1];
		raddr = i_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				q_pop = q_valid;
				we    = q_valid && store_ok;
			end
			ST_SEL_LDI: begin
				raddr = AW'(i_q + CW'(1));
			end
			ST_SEL_SCAN: begin
				raddr = AW'(j_q + CW'(1));
			end
			ST_SEL_WR_I: begin
				we    = 1'b1;
				waddr = i_q[AW-1:0];
				wdata = min_q;
			end
			ST_SEL_WR_M: begin
				we    = 1'b1;
				waddr = m_q[AW-1:0];
				wdata = hold_q;
			end
			ST_INS_LD: begin
				raddr = AW'(i_q - CW'(1));
			end
			ST_INS_CMP: begin
				we    = ins_gt;
				waddr = j_q[AW-1:0];
				wdata = rdata;
				raddr = AW'(j_q - CW'(2));
			end
			ST_INS_WR: begin
				we    = 1'b1;
				waddr = j_q[AW-1:0];
				wdata = hold_q;
			end
			default: begin
				raddr = i_q[AW-1:0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_SEL_LDI: begin
				hold_q <= rdata;
				min_q  <= rdata;
			end
			ST_SEL_SCAN: begin
				if (scan_gt) begin
					min_q <= rdata;
				end
			end
			ST_INS_LD: begin
				hold_q <= rdata;
			end
			ST_EMIT_WAIT: begin
				if (out_free) begin
					out_q.key_out  <= key_wide[31:0];
					out_q.tag_out  <= rdata[TAG_BITS-1:0];
					out_q.last_out <= (i_q + CW'(1) == n_q);
					out_q.overflow <= drop_q;
				end
			end
			default: begin
				hold_q <= hold_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			m_q         <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EMIT_WAIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cnt_q <= cnt_new;
						if (!store_ok) begin
							drop_q <= 1'b1;
						end
						n_q <= cnt_new;
						i_q <= (sort_mode == MODE_BUBBLE || sort_mode == MODE_INSERT)
							&& cnt_new >= CW'(2) ? CW'(1) : CW'(0);
					end
				end
				ST_SEL_LDI: begin
					m_q <= i_q;
					j_q <= i_q + CW'(1);
				end
				ST_SEL_SCAN: begin
					if (scan_gt) begin
						m_q <= j_q;
					end
					j_q <= j_q + CW'(1);
				end
				ST_SEL_WR_M: begin
					i_q <= (i_q + CW'(2) < n_q) ? i_q + CW'(1) : CW'(0);
				end
				ST_INS_LD: begin
					j_q <= i_q;
				end
				ST_INS_CMP: begin
					if (ins_gt) begin
						j_q <= j_q - CW'(1);
					end
				end
				ST_INS_WR: begin
					i_q <= (i_q + CW'(1) < n_q) ? i_q + CW'(1) : CW'(0);
				end
				ST_EMIT_WAIT: begin
					if (out_free) begin
						if (i_q + CW'(1) == n_q) begin
							cnt_q  <= '0;
							drop_q <= 1'b0;
							i_q    <= '0;
						end else begin
							i_q <= i_q + CW'(1);
						end
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ASSERT_NEVER(a_cnt_bound, clk, arst_n, cnt_q > CW'(MAX_ELEMS), "element count beyond capacity")
	`ASSERT_IMPLIES(a_pop_idle, clk, arst_n, q_pop, state_q == ST_IDLE, "queue popped while busy")
	`ASSERT_IMPLIES(a_min_range, clk, arst_n, state_q == ST_SEL_WR_M, m_q < n_q && i_q <= m_q, "minimum index outside the unsorted range")

endmodule
`default_nettype wire

// File: rtl/mode_select_array_sorter.sv
// Loading: one transfer per cycle into a two-entry queue while it is not full, one element per
// cycle into the store while the back end is idle. Sorting: selection mode runs a selection sort;
// bubble and insertion modes both run an insertion sort (quicker on ordered input), all limited
// by the single store read port. Emission: each sorted element is read from the store, then
// registered to the output while it is free. Reset clears all control state and loads
// sort_mode = 2 and compare_signed = 1; the element store is not cleared.
`default_nettype none
module mode_select_array_sorter import mss_pkg::*; #(
	parameter int MAX_ELEMS = MAX_ELEMS_DEF,
	parameter int KEY_BITS  = KEY_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data,
	input  wire logic      cfg_we,
	input  wire logic      cfg_index,
	input  wire logic [1:0] cfg_data
);

	sort_mode_t                  sort_mode_q;
	logic                        compare_signed_q;
	logic                        q_valid;
	logic                        q_pop;
	logic [KEY_BITS+TAG_BITS:0]  q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_mode_q      <= MODE_BUBBLE;
			compare_signed_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SORT_MODE:      sort_mode_q      <= sort_mode_t'(cfg_data);
				REG_COMPARE_SIGNED: compare_signed_q <= cfg_data[0];
				default:            sort_mode_q      <= sort_mode_q;
			endcase
		end
	end

	mss_front #(.KEY_BITS(KEY_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_data   (q_data)
	);

	mss_back #(.MAX_ELEMS(MAX_ELEMS), .KEY_BITS(KEY_BITS)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.sort_mode      (sort_mode_q),
		.compare_signed (compare_signed_q),
		.q_valid        (q_valid),
		.q_pop          (q_pop),
		.q_data         (q_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data)
	);

endmodule
`default_nettype wire
